>>> design/etl_pkg.sv
// Shared types, token kind codes and helpers for the expression token lexer.
`default_nettype none
package etl_pkg;

  // Default width of the byte offset counter
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Width of the span fields on the result channel
  localparam int unsigned SPAN_W = 16;

  // Most descriptors one source byte can cause
  localparam int unsigned MAX_DESC = 3;

  // Bundles held between the front and the back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Token kind codes
  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_NUMBER = 5'd2;
  localparam logic [4:0] KIND_STRING = 5'd3;
  localparam logic [4:0] KIND_AND    = 5'd4;
  localparam logic [4:0] KIND_OR     = 5'd5;
  localparam logic [4:0] KIND_NOT    = 5'd6;
  localparam logic [4:0] KIND_LPAREN = 5'd7;
  localparam logic [4:0] KIND_RPAREN = 5'd8;
  localparam logic [4:0] KIND_EQ     = 5'd9;
  localparam logic [4:0] KIND_EQEQ   = 5'd10;
  localparam logic [4:0] KIND_NE     = 5'd11;
  localparam logic [4:0] KIND_LT     = 5'd12;
  localparam logic [4:0] KIND_LE     = 5'd13;
  localparam logic [4:0] KIND_GT     = 5'd14;
  localparam logic [4:0] KIND_GE     = 5'd15;
  localparam logic [4:0] KIND_PLUS   = 5'd16;
  localparam logic [4:0] KIND_MINUS  = 5'd17;
  localparam logic [4:0] KIND_STAR   = 5'd18;
  localparam logic [4:0] KIND_SLASH  = 5'd19;

  // One token descriptor
  typedef struct packed {
    logic [4:0]        kind;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
  } desc_t;

  // All descriptors caused by one source byte
  typedef struct packed {
    logic [1:0]              cnt;
    desc_t [MAX_DESC-1:0]    d;
  } bundle_t;

  // Back-end status toward the queue
  typedef struct packed {
    logic       pop;
    logic [1:0] idx;
  } back_stat_t;

  function automatic desc_t mk_desc(logic [4:0] kind, logic [SPAN_W-1:0] s,
                                    logic [SPAN_W-1:0] e);
    desc_t r;
    r.kind       = kind;
    r.span_start = s;
    r.span_end   = e;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/expression_token_lexer.sv
// Top level of the expression token lexer: front end, bundle queue and back end.
// The lexer takes one source byte per cycle and emits token descriptors (kind plus
// source span) in order. The front end scans each byte combinationally and writes
// the zero to three descriptors it causes as one bundle into a four-entry queue; bytes
// that cause nothing (whitespace, the middle of a token) never enter the queue. The
// back end delivers one descriptor per cycle through an output register, so the input
// runs at one byte per cycle as long as the result stream keeps pace; a byte that
// closes one token and opens or ends another yields two or three descriptors, which
// the queue absorbs. in_stall rises only when the queue is full. The last descriptor
// caused by a byte carries out_last_token. There is no start-up sweep after reset.
`default_nettype none
module expression_token_lexer #(
  parameter int unsigned POSITION_BITS = etl_pkg::POSITION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_source_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_span_start,
  output logic [15:0]      out_span_end,
  output logic             out_last_token
);

  logic                 q_full, q_empty, q_push;
  etl_pkg::bundle_t     q_data, q_head;
  etl_pkg::back_stat_t  back_stat;

  etl_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_source_byte (in_source_byte),
    .in_last_byte   (in_last_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  etl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (back_stat.pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  etl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head           (q_head),
    .stat           (back_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_span_start (out_span_start),
    .out_span_end   (out_span_end),
    .out_last_token (out_last_token)
  );

  // Queue never written while full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("bundle pushed into full queue");

  // Queue never popped while empty
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !back_stat.pop)
    else $error("bundle popped from empty queue");

  // Back end walk index stays inside the head bundle
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (back_stat.idx < q_head.cnt))
    else $error("descriptor index past end of bundle");

  // A byte marked last always yields a bundle
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |-> q_push)
    else $error("last byte produced no descriptors");

endmodule
`default_nettype wire

>>> design/etl_front.sv
// Front end: accepts source bytes, runs the scan state and builds descriptor bundles.
`default_nettype none
module etl_front #(
  parameter int unsigned POSITION_BITS = etl_pkg::POSITION_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_source_byte,
  input  wire logic             in_last_byte,
  input  wire logic             q_full,
  output logic                  q_push,
  output etl_pkg::bundle_t      q_data
);

  localparam int unsigned SW = etl_pkg::SPAN_W;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_IDENT  = 6'b000010,
    MODE_NUMBER = 6'b000100,
    MODE_STRING = 6'b001000,
    MODE_DOT    = 6'b010000,
    MODE_OP     = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [39:0] chars;
    logic [2:0]  len;
  } kw_t;

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] tstart_r, tstart_nxt;
  kw_t                      kw_r, kw_nxt;
  logic [7:0]               pend_r, pend_nxt;
  logic                     esc_r, esc_nxt;
  logic                     frac_r, frac_nxt;

  logic [POSITION_BITS-1:0] p1;
  logic [SW-1:0]            s_p, s_p1, s_ts;
  logic                     accept;
  etl_pkg::bundle_t         bnd;

  // Character classes
  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Shift one upper-cased byte into the keyword window
  function automatic kw_t kw_add(kw_t k, logic [7:0] c);
    kw_t        r;
    logic [7:0] u;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    r = k;
    if (k.len < 3'd5) begin
      r.chars = {k.chars[31:0], u};
      r.len   = k.len + 3'd1;
    end else begin
      r.len = 3'd6;
    end
    return r;
  endfunction

  function automatic logic [4:0] ident_kind(kw_t k);
    if (k.len == 3'd3 && k.chars == 40'h414E44) return etl_pkg::KIND_AND;
    if (k.len == 3'd2 && k.chars == 40'h4F52) return etl_pkg::KIND_OR;
    if (k.len == 3'd3 && k.chars == 40'h4E4F54) return etl_pkg::KIND_NOT;
    return etl_pkg::KIND_IDENT;
  endfunction

  function automatic logic [4:0] dot_kind(kw_t k);
    if (k.len == 3'd5 && k.chars == 40'h2E414E442E) return etl_pkg::KIND_AND;
    if (k.len == 3'd4 && k.chars == 40'h2E4F522E) return etl_pkg::KIND_OR;
    if (k.len == 3'd5 && k.chars == 40'h2E4E4F542E) return etl_pkg::KIND_NOT;
    return etl_pkg::KIND_IDENT;
  endfunction

  function automatic logic [4:0] op_alone(logic [7:0] op);
    case (op)
      8'h3D:   return etl_pkg::KIND_EQ;
      8'h3C:   return etl_pkg::KIND_LT;
      8'h3E:   return etl_pkg::KIND_GT;
      default: return etl_pkg::KIND_END;
    endcase
  endfunction

  // Saturating next offset
  assign p1 = (pos_r == {POSITION_BITS{1'b1}}) ? pos_r : pos_r + 1'b1;

  // Offsets clamped or zero-extended to the span field width
  if (POSITION_BITS > SW) begin : g_clamp
    assign s_p  = (|pos_r[POSITION_BITS-1:SW])    ? {SW{1'b1}} : pos_r[SW-1:0];
    assign s_p1 = (|p1[POSITION_BITS-1:SW])       ? {SW{1'b1}} : p1[SW-1:0];
    assign s_ts = (|tstart_r[POSITION_BITS-1:SW]) ? {SW{1'b1}} : tstart_r[SW-1:0];
  end else begin : g_ext
    assign s_p  = SW'(pos_r);
    assign s_p1 = SW'(p1);
    assign s_ts = SW'(tstart_r);
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Scan step for one byte
  always_comb begin
    logic [7:0]    c;
    logic          used;
    logic [1:0]    n;
    logic [SW-1:0] ts_c;
    logic [4:0]    k;
    c          = in_source_byte;
    used       = 1'b0;
    n          = 2'd0;
    ts_c       = s_ts;
    k          = etl_pkg::KIND_END;
    bnd        = '0;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    kw_nxt     = kw_r;
    pend_nxt   = pend_r;
    esc_nxt    = esc_r;
    frac_nxt   = frac_r;

    // Continue or close the open token
    unique case (mode_r)
      MODE_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == 8'h5F) begin
          kw_nxt = kw_add(kw_nxt, c);
          used   = 1'b1;
        end else begin
          bnd.d[n] = etl_pkg::mk_desc(ident_kind(kw_nxt), ts_c, s_p);
          n        = n + 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          used = 1'b1;
        end else if (c == 8'h2E && !frac_nxt) begin
          frac_nxt = 1'b1;
          used     = 1'b1;
        end else begin
          bnd.d[n] = etl_pkg::mk_desc(etl_pkg::KIND_NUMBER, ts_c, s_p);
          n        = n + 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        used = 1'b1;
        if (esc_nxt) begin
          esc_nxt = 1'b0;
        end else if (c == 8'h5C) begin
          esc_nxt = 1'b1;
        end else if (c == 8'h22) begin
          bnd.d[n] = etl_pkg::mk_desc(etl_pkg::KIND_STRING, ts_c, s_p1);
          n        = n + 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_DOT: begin
        used   = 1'b1;
        kw_nxt = kw_add(kw_nxt, c);
        if (c == 8'h2E) begin
          bnd.d[n] = etl_pkg::mk_desc(dot_kind(kw_nxt), ts_c, s_p1);
          n        = n + 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_OP: begin
        if (c == 8'h3D) begin
          case (pend_nxt)
            8'h3D:   k = etl_pkg::KIND_EQEQ;
            8'h21:   k = etl_pkg::KIND_NE;
            8'h3C:   k = etl_pkg::KIND_LE;
            default: k = etl_pkg::KIND_GE;
          endcase
          bnd.d[n] = etl_pkg::mk_desc(k, ts_c, s_p1);
          used     = 1'b1;
        end else begin
          bnd.d[n] = etl_pkg::mk_desc(op_alone(pend_nxt), ts_c, s_p);
        end
        n        = n + 2'd1;
        pend_nxt = 8'd0;
        mode_nxt = MODE_IDLE;
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    // Start a new token from idle
    if (!used && !is_space(c)) begin
      tstart_nxt = pos_r;
      ts_c       = s_p;
      if (c == 8'h2E) begin
        mode_nxt = MODE_DOT;
        kw_nxt   = kw_add('0, c);
      end else if (is_alpha(c) || c == 8'h5F) begin
        mode_nxt = MODE_IDENT;
        kw_nxt   = kw_add('0, c);
      end else if (is_digit(c)) begin
        mode_nxt = MODE_NUMBER;
        frac_nxt = 1'b0;
      end else if (c == 8'h22) begin
        mode_nxt = MODE_STRING;
        esc_nxt  = 1'b0;
      end else if (c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E) begin
        mode_nxt = MODE_OP;
        pend_nxt = c;
      end else begin
        case (c)
          8'h28:   k = etl_pkg::KIND_LPAREN;
          8'h29:   k = etl_pkg::KIND_RPAREN;
          8'h2B:   k = etl_pkg::KIND_PLUS;
          8'h2D:   k = etl_pkg::KIND_MINUS;
          8'h2A:   k = etl_pkg::KIND_STAR;
          8'h2F:   k = etl_pkg::KIND_SLASH;
          default: k = etl_pkg::KIND_END;
        endcase
        bnd.d[n] = etl_pkg::mk_desc(k, s_p, s_p1);
        n        = n + 2'd1;
      end
    end

    // End of expression: flush the open token, then the closing end token
    if (in_last_byte) begin
      unique case (mode_nxt)
        MODE_IDENT: begin
          bnd.d[n] = etl_pkg::mk_desc(ident_kind(kw_nxt), ts_c, s_p1);
          n        = n + 2'd1;
        end
        MODE_NUMBER: begin
          bnd.d[n] = etl_pkg::mk_desc(etl_pkg::KIND_NUMBER, ts_c, s_p1);
          n        = n + 2'd1;
        end
        MODE_STRING: begin
          bnd.d[n] = etl_pkg::mk_desc(etl_pkg::KIND_STRING, ts_c, s_p1);
          n        = n + 2'd1;
        end
        MODE_DOT: begin
          bnd.d[n] = etl_pkg::mk_desc(dot_kind(kw_nxt), ts_c, s_p1);
          n        = n + 2'd1;
        end
        MODE_OP: begin
          bnd.d[n] = etl_pkg::mk_desc(op_alone(pend_nxt), ts_c, s_p1);
          n        = n + 2'd1;
        end
        default: begin
        end
      endcase
      bnd.d[n]   = etl_pkg::mk_desc(etl_pkg::KIND_END, s_p1, s_p1);
      n          = n + 2'd1;
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      tstart_nxt = '0;
      kw_nxt     = '0;
      pend_nxt   = 8'd0;
      esc_nxt    = 1'b0;
      frac_nxt   = 1'b0;
    end else begin
      pos_nxt = p1;
    end
    bnd.cnt = n;
  end

  assign q_push = accept && (bnd.cnt != 2'd0);
  assign q_data = bnd;

  // Scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      kw_r     <= '0;
      pend_r   <= 8'd0;
      esc_r    <= 1'b0;
      frac_r   <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      kw_r     <= kw_nxt;
      pend_r   <= pend_nxt;
      esc_r    <= esc_nxt;
      frac_r   <= frac_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/etl_queue.sv
// Small queue of descriptor bundles between the front and the back.
`default_nettype none
module etl_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire etl_pkg::bundle_t  push_data,
  input  wire logic              pop,
  output etl_pkg::bundle_t       head,
  output logic                   full,
  output logic                   empty
);

  localparam int unsigned AW = etl_pkg::QPTR_W;

  etl_pkg::bundle_t mem_r [etl_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r;

  assign full  = (cnt_r == (AW+1)'(etl_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Bundle storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> design/etl_back.sv
// Back end: walks each bundle and delivers one descriptor per transaction.
`default_nettype none
module etl_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire etl_pkg::bundle_t  head,
  output etl_pkg::back_stat_t    stat,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [4:0]             out_token_kind,
  output logic [15:0]            out_span_start,
  output logic [15:0]            out_span_end,
  output logic                   out_last_token
);

  logic             valid_r;
  logic [1:0]       idx_r;
  etl_pkg::desc_t   desc_r;
  logic             last_r;
  logic             load;
  logic             at_last;

  assign load    = !q_empty && (!valid_r || !out_stall);
  assign at_last = (idx_r == head.cnt - 2'd1);

  assign stat.pop = load && at_last;
  assign stat.idx = idx_r;

  // Output valid and bundle walk index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= head.d[idx_r];
      last_r <= at_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_token_kind = desc_r.kind;
  assign out_span_start = desc_r.span_start;
  assign out_span_end   = desc_r.span_end;
  assign out_last_token = last_r;

endmodule
`default_nettype wire
